// File: rtl/idc_pkg.sv
// ----------------------------------------------------------------------------
// idc_pkg
// Shared types and constants for the inertia diagonal combiner.
// ----------------------------------------------------------------------------
package idc_pkg;

  localparam int DATA_W = 32;             // Q16.16 input word
  localparam int SUM_W  = 39;             // position sum width
  localparam int TOT_W  = 48;             // Q32.16 inertia result
  localparam int STEP_W = 6;              // divider step counter width

  typedef struct packed {
    logic [DATA_W-1:0]        part_ixx;
    logic [DATA_W-1:0]        part_iyy;
    logic [DATA_W-1:0]        part_izz;
    logic signed [DATA_W-1:0] part_x;
    logic signed [DATA_W-1:0] part_y;
    logic signed [DATA_W-1:0] part_z;
    logic [DATA_W-1:0]        part_mass;
    logic                     last_part;
  } part_t;

  typedef struct packed {
    logic [TOT_W-1:0]         total_ixx;
    logic [TOT_W-1:0]         total_iyy;
    logic [TOT_W-1:0]         total_izz;
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic signed [DATA_W-1:0] center_z;
    logic                     overflow;
  } result_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store incoming part and add to sums
    logic div_start;   // load the mean dividers
    logic div_step;    // one restoring division step
    logic set_center;  // latch clamped means, clear totals
    logic walk_rd;     // read one stored part into the pipeline
    logic load_out;    // load result register and clear the set
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// File: rtl/idc_if.sv
// ----------------------------------------------------------------------------
// idc_if
// Valid/ready channels for parts and for combined results.
// ----------------------------------------------------------------------------
interface idc_part_if;
  logic          valid;
  logic          ready;
  idc_pkg::part_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface idc_result_if;
  logic            valid;
  logic            ready;
  idc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/idc_datapath.sv
// ----------------------------------------------------------------------------
// idc_datapath
// Part store, position sums, mean dividers, parallel axis pipeline and
// result register.
// ----------------------------------------------------------------------------
module idc_datapath #(
  parameter int MAX_PARTS = 64,
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  idc_pkg::cmd_t        cmd,
  output idc_pkg::status_t     status,
  input  idc_pkg::part_t       in_part,
  input  logic [AW-1:0]        rd_addr,
  output logic [CW-1:0]        count,
  output idc_pkg::result_t     out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);

  localparam int DW   = idc_pkg::DATA_W;
  localparam int SW   = idc_pkg::SUM_W;
  localparam int TW   = idc_pkg::TOT_W;
  localparam int MW   = 7 * DW;
  localparam int NPIPE = 7;
  localparam logic [TW:0] CAP = {1'b0, {TW{1'b1}}};

  // Set state
  logic [CW-1:0]        count_r;
  logic signed [SW-1:0] sum_r [3];
  logic                 dropped_r, sum_sat_r;
  logic                 ov_r;

  // Part store
  logic [MW-1:0] mem [MAX_PARTS];
  logic [MW-1:0] rd_data_r;

  // Divider
  logic [CW-1:0] rem_r [3];
  logic [SW-1:0] quo_r [3];
  logic          neg_r [3];
  logic signed [DW-1:0] center_r [3];

  // Pipeline
  logic [NPIPE-1:0] v_r;
  logic [DW-1:0] mag_r [3];
  logic [TW-1:0] sq_r [3];
  logic [TW:0]   pair_r [3];
  logic [2*DW-1:0] lo_r [3];
  logic [TW:0]   hi_r [3];
  logic [TW-1:0] mterm_r [3];
  logic [TW-1:0] term_r [3];
  logic [TW-1:0] tot_r [3];
  logic [DW-1:0] diag1_r [3], diag2_r [3], diag3_r [3], diag4_r [3], diag5_r [3];
  logic [DW-1:0] mass1_r, mass2_r, mass3_r;

  idc_pkg::result_t out_r;
  logic             out_valid_r;

  logic signed [DW-1:0] pos_in [3];
  logic signed [DW-1:0] pos_rd [3];
  logic [DW-1:0]        diag_rd [3];

  assign pos_in[0] = in_part.part_x;
  assign pos_in[1] = in_part.part_y;
  assign pos_in[2] = in_part.part_z;
  assign diag_rd[0] = rd_data_r[7*DW-1:6*DW];
  assign diag_rd[1] = rd_data_r[6*DW-1:5*DW];
  assign diag_rd[2] = rd_data_r[5*DW-1:4*DW];
  assign pos_rd[0]  = rd_data_r[4*DW-1:3*DW];
  assign pos_rd[1]  = rd_data_r[3*DW-1:2*DW];
  assign pos_rd[2]  = rd_data_r[2*DW-1:DW];

  assign count = count_r;
  assign status.pipe_busy = |v_r;
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // Store incoming part
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CW'(MAX_PARTS))) begin
      mem[count_r[AW-1:0]] <= {in_part.part_ixx, in_part.part_iyy, in_part.part_izz,
                               in_part.part_x, in_part.part_y, in_part.part_z,
                               in_part.part_mass};
    end
    if (cmd.walk_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Count, sums and flags
  always_ff @(posedge clk) begin
    logic signed [SW:0] s;
    logic sat;
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      sum_sat_r <= 1'b0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (cmd.load_out) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      sum_sat_r <= 1'b0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (cmd.load) begin
      if (count_r < CW'(MAX_PARTS)) begin
        count_r <= count_r + 1'b1;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
          s = (SW+1)'(sum_r[k]) + (SW+1)'(pos_in[k]);
          if (s[SW] != s[SW-1]) begin
            sat = 1'b1;
            sum_r[k] <= s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
          end else begin
            sum_r[k] <= s[SW-1:0];
          end
        end
        if (sat) sum_sat_r <= 1'b1;
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // Mean dividers: restoring, one quotient bit per step
  always_ff @(posedge clk) begin
    logic [CW:0] rs;
    if (cmd.div_start) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= '0;
        neg_r[k] <= sum_r[k][SW-1];
        quo_r[k] <= sum_r[k][SW-1] ? SW'(-sum_r[k]) : SW'(sum_r[k]);
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rs = {rem_r[k], quo_r[k][SW-1]};
        if (rs >= {1'b0, count_r}) begin
          rem_r[k] <= CW'(rs - {1'b0, count_r});
          quo_r[k] <= {quo_r[k][SW-2:0], 1'b1};
        end else begin
          rem_r[k] <= rs[CW-1:0];
          quo_r[k] <= {quo_r[k][SW-2:0], 1'b0};
        end
      end
    end
  end

  // Latch clamped centers
  always_ff @(posedge clk) begin
    if (cmd.set_center) begin
      for (int k = 0; k < 3; k++) begin
        if (!neg_r[k] && (quo_r[k] > SW'(32'h7FFF_FFFF))) begin
          center_r[k] <= {1'b0, {(DW-1){1'b1}}};
        end else if (neg_r[k] && (quo_r[k] > SW'(33'h0_8000_0000))) begin
          center_r[k] <= {1'b1, {(DW-1){1'b0}}};
        end else begin
          center_r[k] <= neg_r[k] ? DW'(-quo_r[k]) : DW'(quo_r[k]);
        end
      end
    end
  end

  // Valid chain of the walk pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NPIPE-2:0], cmd.walk_rd};
    end
  end

  // Offset magnitudes
  always_ff @(posedge clk) begin
    logic signed [DW:0] d;
    logic [DW:0] m;
    for (int k = 0; k < 3; k++) begin
      d = (DW+1)'(pos_rd[k]) - (DW+1)'(center_r[k]);
      m = d[DW] ? (DW+1)'(-d) : (DW+1)'(d);
      mag_r[k]   <= m[DW] ? {DW{1'b1}} : m[DW-1:0];
      diag1_r[k] <= diag_rd[k];
    end
    mass1_r <= rd_data_r[DW-1:0];
  end

  // Squares, truncated to Q32.16
  always_ff @(posedge clk) begin
    logic [2*DW-1:0] p;
    for (int k = 0; k < 3; k++) begin
      p = mag_r[k] * mag_r[k];
      sq_r[k]    <= p[2*DW-1:16];
      diag2_r[k] <= diag1_r[k];
    end
    mass2_r <= mass1_r;
  end

  // Pair sums of squares
  always_ff @(posedge clk) begin
    pair_r[0] <= (TW+1)'(sq_r[1]) + (TW+1)'(sq_r[2]);
    pair_r[1] <= (TW+1)'(sq_r[0]) + (TW+1)'(sq_r[2]);
    pair_r[2] <= (TW+1)'(sq_r[0]) + (TW+1)'(sq_r[1]);
    for (int k = 0; k < 3; k++) diag3_r[k] <= diag2_r[k];
    mass3_r <= mass2_r;
  end

  // Mass products as two partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lo_r[k]    <= pair_r[k][DW-1:0] * mass3_r;
      hi_r[k]    <= (TW+1)'(pair_r[k][TW:DW]) * (TW+1)'(mass3_r);
      diag4_r[k] <= diag3_r[k];
    end
  end

  // Combine partial products, saturate; add diagonal, saturate; accumulate
  always_ff @(posedge clk) begin
    logic [TW:0] r;
    logic [TW:0] t;
    logic [TW:0] a;
    logic ov;
    ov = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r = {hi_r[k][TW-16:0], 16'b0} + (TW+1)'(lo_r[k][2*DW-1:16]);
      if (v_r[4] && ((hi_r[k][TW:DW] != '0) || r[TW])) ov = 1'b1;
      mterm_r[k] <= ((hi_r[k][TW:DW] != '0) || r[TW]) ? CAP[TW-1:0] : r[TW-1:0];
      diag5_r[k] <= diag4_r[k];

      t = (TW+1)'(mterm_r[k]) + (TW+1)'(diag5_r[k]);
      if (v_r[5] && t[TW]) ov = 1'b1;
      term_r[k] <= t[TW] ? CAP[TW-1:0] : t[TW-1:0];
    end
    if (cmd.set_center) begin
      ov_r <= 1'b0;
      for (int k = 0; k < 3; k++) tot_r[k] <= '0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        a = (TW+1)'(tot_r[k]) + (TW+1)'(term_r[k]);
        if (v_r[6]) begin
          if (a[TW]) ov = 1'b1;
          tot_r[k] <= a[TW] ? CAP[TW-1:0] : a[TW-1:0];
        end
      end
      if (ov) ov_r <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.total_ixx <= tot_r[0];
      out_r.total_iyy <= tot_r[1];
      out_r.total_izz <= tot_r[2];
      out_r.center_x  <= center_r[0];
      out_r.center_y  <= center_r[1];
      out_r.center_z  <= center_r[2];
      out_r.overflow  <= ov_r || dropped_r || sum_sat_r;
    end
  end

endmodule

// File: rtl/idc_ctrl.sv
// ----------------------------------------------------------------------------
// idc_ctrl
// Sequencer: load parts, divide for the means, walk the store, emit result.
// ----------------------------------------------------------------------------
module idc_ctrl #(
  parameter int CW = 7,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  logic [CW-1:0]    count,
  input  idc_pkg::status_t status,
  output idc_pkg::cmd_t    cmd,
  output logic [AW-1:0]    rd_addr
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_CENT   = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [idc_pkg::STEP_W-1:0] LAST_STEP =
    idc_pkg::STEP_W'(idc_pkg::SUM_W - 1);

  logic [2:0] state_r, state_nxt;
  logic [idc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [CW-1:0] addr_r, addr_nxt;

  assign rd_addr = addr_r[AW-1:0];

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    addr_nxt  = addr_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) state_nxt = S_CENT;
      end
      S_CENT: begin
        cmd.set_center = 1'b1;
        addr_nxt       = '0;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        addr_nxt    = addr_r + 1'b1;
        if (addr_nxt == count) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.pipe_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// File: rtl/inertia_diagonal_combiner.sv
// ----------------------------------------------------------------------------
// inertia_diagonal_combiner
// Combines rigid part inertia diagonals about the mean part position.
// ----------------------------------------------------------------------------
// Parts are taken one per cycle and stored; up to MAX_PARTS are kept, later
// ones are dropped and flag overflow. A part marked last (stored or not)
// starts combining: the three restoring dividers are loaded, 39 division
// steps give the mean position and the centers are latched; then one stored
// part per cycle goes through a 7-stage parallel axis pipeline, and once
// the pipeline has drained the result register is loaded. The store's
// single read port sets the per-part walk rate.
// No part is taken while combining; a finished result may wait in its
// register while the next set loads.
// ----------------------------------------------------------------------------
module inertia_diagonal_combiner #(
  parameter int MAX_PARTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  idc_part_if.sink     in_ch,
  idc_result_if.source out_ch
);

  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

  idc_pkg::cmd_t    cmd;
  idc_pkg::status_t status;
  logic [CW-1:0]    count;
  logic [AW-1:0]    rd_addr;

  // Sequencer
  idc_ctrl #(.CW(CW), .AW(AW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.data.last_part),
    .in_ready (in_ch.ready),
    .count    (count),
    .status   (status),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // Store and arithmetic
  idc_datapath #(.MAX_PARTS(MAX_PARTS), .CW(CW), .AW(AW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_part   (in_ch.data),
    .rd_addr   (rd_addr),
    .count     (count),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule
